// File: design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, codes and helpers of the bitplane scanline renderer.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int LINE_PIXELS_DEF = 320;
    localparam int OUTPUT_ROWS_DEF = 256;

    localparam int NUM_PLANES  = 6;
    localparam int PLANE_AW    = 3;
    localparam int NUM_COLOURS = 32;
    localparam int COLOUR_AW   = 5;
    localparam int COLOUR_BITS = 12;
    localparam int ADDR_BITS   = 21;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] MODE_REG  = 2'd0;
    localparam logic [1:0] MODE_SCAN = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    localparam logic [5:0] REG_PTR0     = 6'd32;
    localparam logic [5:0] REG_CTRL     = 6'd38;
    localparam logic [5:0] REG_SCROLL   = 6'd39;
    localparam logic [5:0] REG_ODD_MOD  = 6'd40;
    localparam logic [5:0] REG_EVEN_MOD = 6'd41;
    localparam logic [5:0] REG_WSTART   = 6'd42;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [8:0] DEFAULT_START = 9'd44;
    localparam logic [2:0] MAX_PLANES    = 3'd6;
    localparam logic [2:0] LAST_BIT      = 3'd7;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           plane;
        logic                 snap;
        logic [ADDR_BITS-1:0] preg;
        logic [ADDR_BITS-1:0] addend;
        logic                 emit;
        logic                 cvalid;
        logic                 halve;
        logic [7:0]           row;
        logic [8:0]           x;
        logic                 last;
    } t_op;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           plane;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           row;
        logic [8:0]           x;
        logic [23:0]          rgb;
        logic                 last;
    } t_result;

    function automatic logic [23:0] expand_colour(input logic [11:0] c);
        return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
    endfunction

    function automatic logic [23:0] halve_colour(input logic [23:0] c);
        return {1'b0, c[23:17], 1'b0, c[15:9], 1'b0, c[7:1]};
    endfunction

endpackage

// File: design/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bsr_issue.sv
// ----------------------------------------------------------------------------
// bsr_issue
// Item decode, control registers and the per-pixel / per-plane sequencer.
// ----------------------------------------------------------------------------
module bsr_issue #(
    parameter int LINE_PIXELS = bsr_pkg::LINE_PIXELS_DEF,
    parameter int OUTPUT_ROWS = bsr_pkg::OUTPUT_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [5:0]                          i_reg_sel,
    input  logic [20:0]                         i_reg_value,
    input  logic [8:0]                          i_line_number,
    input  logic [5:0]                          i_byte_column,
    input  logic [47:0]                         i_plane_bytes,
    input  logic                                i_room,
    output logic                                o_op_valid,
    output bsr_pkg::t_op                        o_op,
    output logic [bsr_pkg::COLOUR_AW-1:0]       o_crd_addr,
    output logic [bsr_pkg::PLANE_AW-1:0]        o_prd_addr,
    output logic                                o_cwr_en,
    output logic [bsr_pkg::COLOUR_AW-1:0]       o_cwr_addr,
    output logic [bsr_pkg::COLOUR_BITS-1:0]     o_cwr_data
);

    import bsr_pkg::*;

    localparam logic [10:0] HI_OFFSET = 11'(LINE_PIXELS - 1);
    localparam logic [10:0] SPAN      = 11'd7;
    localparam logic [9:0]  ROWS_LIM  = 10'(OUTPUT_ROWS);
    localparam logic [20:0] LINE_STEP = 21'(LINE_PIXELS / 8);

    logic [NUM_COLOURS-1:0] r_cvalid;
    logic [ADDR_BITS-1:0]   r_preg [NUM_PLANES];
    logic [2:0]             r_pc;
    logic                   r_hb;
    logic [3:0]             r_scroll;
    logic [15:0]            r_odd_mod;
    logic [15:0]            r_even_mod;
    logic [7:0]             r_wstart;
    logic                   r_snapped;
    logic [7:0]             r_row;
    logic                   r_row_active;
    logic                   r_busy;
    logic [2:0]             r_cnt;
    logic [2:0]             r_end;

    logic                   r_kind;
    logic                   r_snap;
    logic                   r_emit;
    logic [47:0]            r_bytes;
    logic [8:0]             r_x;

    logic issue, last_op, ready, accept;

    // data item decode
    logic [10:0] d_base, d_sc, d_hi, d_lo_off, d_hi_off;
    logic [2:0]  d_bstart, d_bend;
    logic        d_ok_lo, d_ok_hi, d_ok;
    logic [10:0] d_x0;

    // scanline decode
    logic [8:0] s_start, s_outy;
    logic       s_snapped_eff, s_snap, s_snapped_n, s_ge, s_active, s_ops;
    logic [2:0] s_end;

    // op generation
    logic [5:0]  idx;
    logic [7:0]  pl_byte;
    logic [15:0] mod_sel;
    logic        plane_in;

    assign issue      = r_busy && i_room;
    assign last_op    = (r_cnt == r_end);
    assign ready      = !r_busy || (issue && last_op);
    assign accept     = i_in_valid && ready;
    assign o_in_stall = !ready;

    always_comb begin
        d_base   = {2'b00, i_byte_column, 3'b000};
        d_sc     = {7'd0, r_scroll};
        d_hi     = d_sc + HI_OFFSET;
        d_lo_off = d_sc - d_base;
        d_hi_off = d_hi - d_base;
        if (d_base >= d_sc) begin
            d_bstart = 3'd0;
            d_ok_lo  = 1'b1;
        end else begin
            d_bstart = d_lo_off[2:0];
            d_ok_lo  = (d_lo_off <= SPAN);
        end
        if (d_hi >= d_base + SPAN) begin
            d_bend  = 3'd7;
            d_ok_hi = 1'b1;
        end else begin
            d_bend  = d_hi_off[2:0];
            d_ok_hi = (d_hi >= d_base);
        end
        d_ok = d_ok_lo && d_ok_hi && (d_bstart <= d_bend) && r_row_active && (r_pc != 3'd0);
        d_x0 = d_base + {8'd0, d_bstart} - d_sc;
    end

    always_comb begin
        s_start       = (r_wstart == 8'd0) ? DEFAULT_START : {1'b0, r_wstart};
        s_snapped_eff = r_snapped && (i_line_number != 9'd0);
        s_snap        = (i_line_number == s_start) && !s_snapped_eff;
        s_snapped_n   = s_snapped_eff || s_snap;
        s_ge          = (i_line_number >= s_start);
        s_outy        = i_line_number - s_start;
        s_active      = s_snapped_n && s_ge && ({1'b0, s_outy} < ROWS_LIM) && (r_pc != 3'd0);
        s_ops         = s_snap || (s_snapped_n && s_ge && (r_pc != 3'd0));
        s_end         = s_snap ? (MAX_PLANES - 3'd1) : (r_pc - 3'd1);
    end

    always_comb begin
        idx = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            pl_byte = r_bytes[8*p +: 8];
            idx[p]  = (3'(p) < r_pc) && pl_byte[LAST_BIT - r_cnt];
        end
        mod_sel  = r_cnt[0] ? r_even_mod : r_odd_mod;
        plane_in = (r_cnt < r_pc);

        o_op        = '0;
        o_op.kind   = r_kind;
        o_op.row    = r_row;
        o_op.last   = last_op;
        if (r_kind == KIND_PIXEL) begin
            o_op.cvalid = r_cvalid[idx[4:0]];
            o_op.halve  = idx[5] && r_hb;
            o_op.x      = r_x;
        end else begin
            o_op.plane  = r_cnt;
            o_op.snap   = r_snap;
            o_op.preg   = r_preg[r_cnt];
            o_op.addend = plane_in ? (LINE_STEP + {{5{mod_sel[15]}}, mod_sel}) : '0;
            o_op.emit   = r_emit && plane_in;
            o_op.last   = r_emit && (r_cnt == r_pc - 3'd1);
        end
    end

    assign o_op_valid = issue;
    assign o_crd_addr = idx[4:0];
    assign o_prd_addr = r_cnt;
    assign o_cwr_en   = accept && (i_mode == MODE_REG) && (i_reg_sel < REG_PTR0);
    assign o_cwr_addr = i_reg_sel[4:0];
    assign o_cwr_data = i_reg_value[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid     <= '0;
            r_pc         <= '0;
            r_hb         <= 1'b0;
            r_scroll     <= '0;
            r_odd_mod    <= '0;
            r_even_mod   <= '0;
            r_wstart     <= '0;
            r_snapped    <= 1'b0;
            r_row        <= '0;
            r_row_active <= 1'b0;
            r_busy       <= 1'b0;
            r_cnt        <= '0;
            r_end        <= '0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_preg[p] <= '0;
            end
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + 3'd1;
                if (last_op) begin
                    r_busy <= 1'b0;
                end
            end
            if (accept) begin
                unique case (i_mode)
                    MODE_REG: begin
                        priority if (i_reg_sel < REG_PTR0) begin
                            r_cvalid[i_reg_sel[4:0]] <= 1'b1;
                        end else if (i_reg_sel < REG_CTRL) begin
                            r_preg[3'(i_reg_sel - REG_PTR0)] <= i_reg_value;
                        end else if (i_reg_sel == REG_CTRL) begin
                            r_pc <= (i_reg_value[14:12] > MAX_PLANES) ? MAX_PLANES
                                                                      : i_reg_value[14:12];
                            r_hb <= i_reg_value[7];
                        end else if (i_reg_sel == REG_SCROLL) begin
                            r_scroll <= i_reg_value[3:0];
                        end else if (i_reg_sel == REG_ODD_MOD) begin
                            r_odd_mod <= i_reg_value[15:0];
                        end else if (i_reg_sel == REG_EVEN_MOD) begin
                            r_even_mod <= i_reg_value[15:0];
                        end else if (i_reg_sel == REG_WSTART) begin
                            r_wstart <= i_reg_value[7:0];
                        end else begin
                        end
                    end
                    MODE_SCAN: begin
                        r_snapped    <= s_snapped_n;
                        r_row_active <= s_active;
                        if (s_active) begin
                            r_row <= s_outy[7:0];
                        end
                        if (s_ops) begin
                            r_busy <= 1'b1;
                            r_cnt  <= 3'd0;
                            r_end  <= s_end;
                        end
                    end
                    MODE_DATA: begin
                        if (d_ok) begin
                            r_busy <= 1'b1;
                            r_cnt  <= d_bstart;
                            r_end  <= d_bend;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_x <= r_x + 9'd1;
        end
        if (accept && (i_mode == MODE_SCAN)) begin
            r_kind <= KIND_FETCH;
            r_snap <= s_snap;
            r_emit <= s_active;
        end
        if (accept && (i_mode == MODE_DATA)) begin
            r_kind  <= KIND_PIXEL;
            r_bytes <= i_plane_bytes;
            r_x     <= d_x0[8:0];
        end
    end

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= r_end))
        else $error("sequencer count ran past its end");

    a_issue_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_valid |-> i_room)
        else $error("op issued without queue room");

endmodule

// File: design/bsr_finish.sv
// ----------------------------------------------------------------------------
// bsr_finish
// RAM return stage: colour expansion, pointer write-back with forwarding.
// ----------------------------------------------------------------------------
module bsr_finish (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_op_valid,
    input  bsr_pkg::t_op                        i_op,
    input  logic [bsr_pkg::COLOUR_BITS-1:0]     i_crd_data,
    input  logic [bsr_pkg::ADDR_BITS-1:0]       i_prd_data,
    output logic                                o_pwr_en,
    output logic [bsr_pkg::PLANE_AW-1:0]        o_pwr_addr,
    output logic [bsr_pkg::ADDR_BITS-1:0]       o_pwr_data,
    output logic                                o_s1_valid,
    output logic                                o_push,
    output bsr_pkg::t_result                    o_res
);

    import bsr_pkg::*;

    logic                  r_s1_valid;
    t_op                   r_s1;
    logic                  r_fwd_hit;
    logic [ADDR_BITS-1:0]  r_fwd_data;
    logic [NUM_PLANES-1:0] r_lvalid;
    logic                  r_s1_lv;

    logic [ADDR_BITS-1:0]  base, val;
    logic [23:0]           rgb;

    always_comb begin
        if (r_fwd_hit) begin
            base = r_fwd_data;
        end else begin
            base = r_s1_lv ? i_prd_data : '0;
        end
        val = r_s1.snap ? r_s1.preg : base;
        rgb = expand_colour(r_s1.cvalid ? i_crd_data : '0);
        if (r_s1.halve) begin
            rgb = halve_colour(rgb);
        end
    end

    assign o_pwr_en   = r_s1_valid && (r_s1.kind == KIND_FETCH);
    assign o_pwr_addr = r_s1.plane;
    assign o_pwr_data = val + r_s1.addend;
    assign o_s1_valid = r_s1_valid;
    assign o_push     = r_s1_valid && ((r_s1.kind == KIND_PIXEL) || r_s1.emit);

    always_comb begin
        o_res       = '0;
        o_res.kind  = r_s1.kind;
        o_res.row   = r_s1.row;
        o_res.last  = r_s1.last;
        if (r_s1.kind == KIND_PIXEL) begin
            o_res.x   = r_s1.x;
            o_res.rgb = rgb;
        end else begin
            o_res.plane = r_s1.plane;
            o_res.addr  = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_lvalid   <= '0;
        end else begin
            r_s1_valid <= i_op_valid;
            r_fwd_hit  <= i_op_valid && (i_op.kind == KIND_FETCH) && o_pwr_en
                          && (o_pwr_addr == i_op.plane);
            if (o_pwr_en) begin
                r_lvalid[o_pwr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= i_op;
        r_fwd_data <= o_pwr_data;
        r_s1_lv    <= r_lvalid[i_op.plane];
    end

    a_fwd_only_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> (r_s1_valid && (r_s1.kind == KIND_FETCH)))
        else $error("forward hit on a non-pointer op");

endmodule

// File: design/bsr_outq.sv
// ----------------------------------------------------------------------------
// bsr_outq
// Result queue between the return stage and the output channel.
// ----------------------------------------------------------------------------
module bsr_outq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bsr_pkg::t_result             i_res,
    output logic                         o_valid,
    input  logic                         i_stall,
    output bsr_pkg::t_result             o_res,
    output logic [bsr_pkg::OQ_CW-1:0]    o_count
);

    import bsr_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_head;
    logic [OQ_AW-1:0] r_tail;
    logic [OQ_CW-1:0] r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_head];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + OQ_AW'(1);
            end
            if (pop) begin
                r_head <= r_head + OQ_AW'(1);
            end
            r_count <= r_count + OQ_CW'(i_push) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_res;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < OQ_CW'(OQ_DEPTH) || pop))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) + OQ_CW'($past(i_push)) - OQ_CW'($past(pop))))
        else $error("result queue count lost track");

endmodule

// File: design/bitplane_scanline_renderer_core.sv
// Results of an item are registered in the return stage and then in the result queue
// before they reach the output.
// Throughput: one result per cycle while the result queue has room; a data item issues one
// op per emitted pixel (up to 8), a scanline item one op per pointer visited (the plane count,
// or 6 at the snapshot). The rate is set by the single read port of each RAM.
// Reset is synchronous: it clears control registers and RAM entry valid bits, so every
// colour and pointer reads as zero until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bitplane_scanline_renderer_core
// Planar-to-chunky scanline renderer with half-brite palette and fetch requests.
// ----------------------------------------------------------------------------
module bitplane_scanline_renderer_core #(
    parameter int LINE_PIXELS = bsr_pkg::LINE_PIXELS_DEF,
    parameter int OUTPUT_ROWS = bsr_pkg::OUTPUT_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_reg_sel,
    input  logic [20:0] i_reg_value,
    input  logic [8:0]  i_line_number,
    input  logic [5:0]  i_byte_column,
    input  logic [47:0] i_plane_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [2:0]  o_plane,
    output logic [20:0] o_fetch_address,
    output logic [7:0]  o_row,
    output logic [8:0]  o_column_x,
    output logic [23:0] o_pixel_rgb,
    output logic        o_last
);

    import bsr_pkg::*;

    logic                   op_valid;
    t_op                    op;
    logic [COLOUR_AW-1:0]   crd_addr, cwr_addr;
    logic [PLANE_AW-1:0]    prd_addr, pwr_addr;
    logic                   cwr_en, pwr_en;
    logic [COLOUR_BITS-1:0] cwr_data, crd_data;
    logic [ADDR_BITS-1:0]   pwr_data, prd_data;
    logic                   s1_valid, push;
    t_result                res, q_res;
    logic [OQ_CW-1:0]       q_count;
    logic                   room;

    assign room = ({1'b0, q_count} + (OQ_CW+1)'(s1_valid)) < (OQ_CW+1)'(OQ_DEPTH);

    bsr_issue #(
        .LINE_PIXELS (LINE_PIXELS),
        .OUTPUT_ROWS (OUTPUT_ROWS)
    ) u_issue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_reg_sel     (i_reg_sel),
        .i_reg_value   (i_reg_value),
        .i_line_number (i_line_number),
        .i_byte_column (i_byte_column),
        .i_plane_bytes (i_plane_bytes),
        .i_room        (room),
        .o_op_valid    (op_valid),
        .o_op          (op),
        .o_crd_addr    (crd_addr),
        .o_prd_addr    (prd_addr),
        .o_cwr_en      (cwr_en),
        .o_cwr_addr    (cwr_addr),
        .o_cwr_data    (cwr_data)
    );

    bsr_ram #(
        .WIDTH (COLOUR_BITS),
        .DEPTH (NUM_COLOURS)
    ) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (cwr_en),
        .i_waddr (cwr_addr),
        .i_wdata (cwr_data),
        .i_raddr (crd_addr),
        .o_rdata (crd_data)
    );

    bsr_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (NUM_PLANES)
    ) u_pointer_ram (
        .i_clk   (i_clk),
        .i_we    (pwr_en),
        .i_waddr (pwr_addr),
        .i_wdata (pwr_data),
        .i_raddr (prd_addr),
        .o_rdata (prd_data)
    );

    bsr_finish u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .i_crd_data (crd_data),
        .i_prd_data (prd_data),
        .o_pwr_en   (pwr_en),
        .o_pwr_addr (pwr_addr),
        .o_pwr_data (pwr_data),
        .o_s1_valid (s1_valid),
        .o_push     (push),
        .o_res      (res)
    );

    bsr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (q_res),
        .o_count (q_count)
    );

    assign o_kind          = q_res.kind;
    assign o_plane         = q_res.plane;
    assign o_fetch_address = q_res.addr;
    assign o_row           = q_res.row;
    assign o_column_x      = q_res.x;
    assign o_pixel_rgb     = q_res.rgb;
    assign o_last          = q_res.last;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitplane scanline renderer core. Register
// writes, scanline items and plane data go in over a valid/stall channel with
// random gaps; an in-bench model of the palette, plane pointers and scroll
// logic predicts every fetch request and pixel, and each output transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bsr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [5:0] REG_NONE    = 6'd63;
    localparam int LINE_BYTES  = LINE_PIXELS_DEF / 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 310;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [5:0]  i_reg_sel;
    logic [20:0] i_reg_value;
    logic [8:0]  i_line_number;
    logic [5:0]  i_byte_column;
    logic [47:0] i_plane_bytes;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic [2:0]  o_plane;
    logic [20:0] o_fetch_address;
    logic [7:0]  o_row;
    logic [8:0]  o_column_x;
    logic [23:0] o_pixel_rgb;
    logic        o_last;

    // predicted renderer state
    logic [11:0] pal [NUM_COLOURS];
    logic [20:0] base_ptr [NUM_PLANES];
    logic [20:0] run_ptr [NUM_PLANES];
    logic [2:0]  plane_cnt;
    logic        ehb_on;
    logic [3:0]  hscroll;
    logic [15:0] odd_mod;
    logic [15:0] even_mod;
    logic [7:0]  win_start;
    logic        snap_done;
    logic [7:0]  row_now;
    logic        row_live;

    t_result render_q [$];

    int  n_errors;
    int  cycle_cnt;
    int  rx_wait;
    int  hold_left;
    bit  tx_lazy;
    bit  rx_lazy;

    bitplane_scanline_renderer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_reg_sel       (i_reg_sel),
        .i_reg_value     (i_reg_value),
        .i_line_number   (i_line_number),
        .i_byte_column   (i_byte_column),
        .i_plane_bytes   (i_plane_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_plane         (o_plane),
        .o_fetch_address (o_fetch_address),
        .o_row           (o_row),
        .o_column_x      (o_column_x),
        .o_pixel_rgb     (o_pixel_rgb),
        .o_last          (o_last)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (n_errors < 40) begin
            $display("cycle %0d: %s", cycle_cnt, msg);
        end
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want) begin
            report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic logic [23:0] pixel_colour(input logic [5:0] idx);
        logic [11:0] c;
        logic [23:0] rgb;
        c   = pal[idx[4:0]];
        rgb = {8'(c[11:8]) * 8'h11, 8'(c[7:4]) * 8'h11, 8'(c[3:0]) * 8'h11};
        if (idx[5] && ehb_on) begin
            rgb = (rgb >> 1) & 24'h7F7F7F;
        end
        return rgb;
    endfunction

    task automatic push_result(input logic kind, input logic [2:0] plane,
                               input logic [20:0] addr, input logic [7:0] row,
                               input logic [8:0] x, input logic [23:0] rgb);
        t_result r;
        r.kind  = kind;
        r.plane = plane;
        r.addr  = addr;
        r.row   = row;
        r.x     = x;
        r.rgb   = rgb;
        r.last  = 1'b0;
        render_q.push_back(r);
    endtask

    task automatic render_predict(input logic [1:0] mode, input logic [5:0] sel,
                                  input logic [20:0] val, input logic [8:0] line,
                                  input logic [5:0] col, input logic [47:0] bytes);
        int          n_out;
        int          p;
        int          b;
        int          src;
        int          x;
        logic [8:0]  start;
        logic [8:0]  out_y;
        logic [5:0]  idx;
        logic [15:0] m;
        n_out = 0;
        case (mode)
            MODE_REG: begin
                if (sel < REG_PTR0) begin
                    pal[sel[4:0]] = val[11:0];
                end else if (sel < REG_CTRL) begin
                    base_ptr[3'(sel - REG_PTR0)] = val;
                end else if (sel == REG_CTRL) begin
                    plane_cnt = (val[14:12] > MAX_PLANES) ? MAX_PLANES : val[14:12];
                    ehb_on    = val[7];
                end else if (sel == REG_SCROLL) begin
                    hscroll = val[3:0];
                end else if (sel == REG_ODD_MOD) begin
                    odd_mod = val[15:0];
                end else if (sel == REG_EVEN_MOD) begin
                    even_mod = val[15:0];
                end else if (sel == REG_WSTART) begin
                    win_start = val[7:0];
                end
            end
            MODE_SCAN: begin
                start = (win_start == 8'd0) ? DEFAULT_START : {1'b0, win_start};
                if (line == 9'd0) begin
                    snap_done = 1'b0;
                end
                if (line == start && !snap_done) begin
                    for (p = 0; p < NUM_PLANES; p++) begin
                        run_ptr[p] = base_ptr[p];
                    end
                    snap_done = 1'b1;
                end
                row_live = 1'b0;
                if (snap_done && line >= start) begin
                    out_y = line - start;
                    if (out_y < OUTPUT_ROWS_DEF && plane_cnt != 3'd0) begin
                        row_now  = out_y[7:0];
                        row_live = 1'b1;
                        for (p = 0; p < plane_cnt; p++) begin
                            push_result(KIND_FETCH, 3'(p), run_ptr[p], row_now, 9'd0, 24'd0);
                            n_out++;
                        end
                    end
                    for (p = 0; p < plane_cnt; p++) begin
                        m = p[0] ? even_mod : odd_mod;
                        run_ptr[p] = run_ptr[p] + 21'(LINE_BYTES) + {{5{m[15]}}, m};
                    end
                end
            end
            MODE_DATA: begin
                if (row_live && plane_cnt != 3'd0) begin
                    for (b = 0; b < 8; b++) begin
                        src = int'(col) * 8 + b;
                        x   = src - int'(hscroll);
                        if (src >= int'(hscroll) && x < LINE_PIXELS_DEF) begin
                            idx = 6'd0;
                            for (p = 0; p < plane_cnt; p++) begin
                                idx[p] = bytes[8 * p + 7 - b];
                            end
                            push_result(KIND_PIXEL, 3'd0, 21'd0, row_now, 9'(x),
                                        pixel_colour(idx));
                            n_out++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (n_out > 0) begin
            render_q[render_q.size() - 1].last = 1'b1;
        end
    endtask

    // one input transfer; entered and left at a falling edge
    task automatic drive_item(input logic [1:0] mode, input logic [5:0] sel,
                              input logic [20:0] val, input logic [8:0] line,
                              input logic [5:0] col, input logic [47:0] bytes);
        int gap;
        gap = tx_lazy ? $urandom_range(0, 7) : 0;
        repeat (gap) @(negedge i_clk);
        i_mode        = mode;
        i_reg_sel     = sel;
        i_reg_value   = val;
        i_line_number = line;
        i_byte_column = col;
        i_plane_bytes = bytes;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        render_predict(mode, sel, val, line, col, bytes);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand_bytes();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic write_reg(input logic [5:0] sel, input logic [20:0] val);
        drive_item(MODE_REG, sel, val, 9'($urandom), 6'($urandom), rand_bytes());
    endtask

    task automatic scan_line(input logic [8:0] line);
        drive_item(MODE_SCAN, 6'($urandom), 21'($urandom), line, 6'($urandom), rand_bytes());
    endtask

    task automatic plane_data(input logic [5:0] col, input logic [47:0] bytes);
        drive_item(MODE_DATA, 6'($urandom), 21'($urandom), 9'($urandom), col, bytes);
    endtask

    task automatic drain();
        while (render_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // output checker and per-transfer receiver delay
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (render_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d row %0d", o_kind, o_row));
            end else begin
                want = render_q.pop_front();
                check_field("kind", 24'(o_kind), 24'(want.kind));
                check_field("plane", 24'(o_plane), 24'(want.plane));
                check_field("fetch_address", 24'(o_fetch_address), 24'(want.addr));
                check_field("row", 24'(o_row), 24'(want.row));
                check_field("column_x", 24'(o_column_x), 24'(want.x));
                check_field("pixel_rgb", o_pixel_rgb, want.rgb);
                check_field("last", 24'(o_last), 24'(want.last));
            end
            rx_wait = rx_lazy ? $urandom_range(0, 7) : 0;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (rx_wait > 0) begin
                i_out_stall = 1'b1;
                rx_wait--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic test_idle_quiet();
        plane_data(6'd0, 48'hFFFF_FFFF_FFFF);
        scan_line(9'd0);
        scan_line(9'(DEFAULT_START));
        drain();
    endtask

    task automatic test_fetch_edges();
        write_reg(REG_PTR0, 21'h1FFFFF);
        write_reg(REG_PTR0 + 6'd3, 21'h155555);
        write_reg(REG_ODD_MOD, 21'h008000);
        write_reg(REG_EVEN_MOD, 21'h007FFF);
        write_reg(REG_CTRL, 21'h007080);
        scan_line(9'd0);
        scan_line(9'(DEFAULT_START));
        scan_line(9'(DEFAULT_START) + 9'd1);
        scan_line(9'(DEFAULT_START) + 9'd255);
        scan_line(9'(DEFAULT_START) + 9'd256);
        plane_data(6'd3, rand_bytes());
        drain();
    endtask

    task automatic test_pixels();
        write_reg(6'd31, 21'h000FFF);
        write_reg(6'd1, 21'h0008C3);
        scan_line(9'd0);
        scan_line(9'(DEFAULT_START));
        plane_data(6'd0, 48'hFFFF_FFFF_FFFF);
        plane_data(6'd5, 48'h0102_0408_1020);
        plane_data(6'd39, rand_bytes());
        plane_data(6'd41, rand_bytes());
        write_reg(REG_SCROLL, 21'h00000F);
        plane_data(6'd0, rand_bytes());
        plane_data(6'd1, rand_bytes());
        write_reg(REG_CTRL, 21'h006000);
        plane_data(6'd2, 48'hFFFF_FFFF_FFFF);
        drive_item(MODE_UNUSED, 6'($urandom), 21'($urandom), 9'($urandom), 6'($urandom),
                   rand_bytes());
        write_reg(REG_NONE, 21'h1FFFFF);
        write_reg(REG_CTRL, 21'h000000);
        scan_line(9'(DEFAULT_START) + 9'd1);
        plane_data(6'd4, rand_bytes());
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_WSTART, 21'd0);
        write_reg(REG_SCROLL, 21'd0);
        write_reg(REG_CTRL, 21'h006080);
        scan_line(9'd0);
        scan_line(9'(DEFAULT_START));
        @(posedge i_clk);
        hold_left = 150;
        @(negedge i_clk);
        tx_lazy = 1'b0;
        repeat (12) plane_data(6'($urandom_range(0, 39)), rand_bytes());
        tx_lazy = 1'b1;
        drain();
    endtask

    task automatic random_write();
        logic [5:0] sel;
        case ($urandom_range(0, 3))
            0:       sel = REG_CTRL;
            1:       sel = 6'($urandom_range(REG_SCROLL, REG_WSTART));
            default: sel = 6'($urandom_range(0, REG_EVEN_MOD));
        endcase
        write_reg(sel, 21'($urandom));
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: drive_item(MODE_UNUSED, 6'($urandom), 21'($urandom), 9'($urandom),
                          6'($urandom), rand_bytes());
            1: write_reg(6'($urandom_range(REG_WSTART + 1, REG_NONE)), 21'($urandom));
            2: scan_line(9'($urandom_range(0, 511)));
            default: plane_data(6'($urandom_range(0, 41)), rand_bytes());
        endcase
    endtask

    task automatic test_random();
        int         sent;
        int         r;
        int         line;
        logic [8:0] start;
        sent = 0;
        for (r = 0; r <= REG_WSTART; r++) begin
            write_reg(6'(r), 21'($urandom));
            sent++;
        end
        while (sent < RANDOM_ITEMS) begin
            tx_lazy = $urandom_range(0, 3) != 0;
            rx_lazy = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(0, 3)) begin
                random_write();
                sent++;
            end
            if ($urandom_range(0, 4) == 0) begin
                noise_item();
            end
            scan_line(9'd0);
            sent++;
            start = (win_start == 8'd0) ? DEFAULT_START : {1'b0, win_start};
            line  = int'(start);
            repeat ($urandom_range(1, 4)) begin
                if (line <= 511) begin
                    scan_line(9'(line));
                    sent++;
                    repeat ($urandom_range(0, 4)) begin
                        plane_data(6'($urandom_range(0, 41)), rand_bytes());
                        sent++;
                    end
                    line += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 1;
                end
            end
        end
        tx_lazy = 1'b1;
        rx_lazy = 1'b1;
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_REG;
        i_reg_sel     = 6'd0;
        i_reg_value   = 21'd0;
        i_line_number = 9'd0;
        i_byte_column = 6'd0;
        i_plane_bytes = 48'd0;
        n_errors      = 0;
        cycle_cnt     = 0;
        rx_wait       = 0;
        hold_left     = 0;
        tx_lazy       = 1'b1;
        rx_lazy       = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            base_ptr[p] = 21'd0;
            run_ptr[p]  = 21'd0;
        end
        for (int c = 0; c < NUM_COLOURS; c++) begin
            pal[c] = 12'd0;
        end
        plane_cnt = 3'd0;
        ehb_on    = 1'b0;
        hscroll   = 4'd0;
        odd_mod   = 16'd0;
        even_mod  = 16'd0;
        win_start = 8'd0;
        snap_done = 1'b0;
        row_now   = 8'd0;
        row_live  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_idle_quiet();
        test_fetch_edges();
        test_pixels();
        test_backpressure();
        test_random();

        if (n_errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
